### src/bik_pkg.sv
// ----------------------------------------------------------------------------
// Bicubic kernel package
// Shared widths, defaults and pipeline constants for the bicubic kernel.
// ----------------------------------------------------------------------------
package bik_pkg;

  localparam int COLUMN_BITS      = 32;
  localparam int FRAC_FIELD_BITS  = 8;
  localparam int PIXEL_BITS       = 8;
  localparam int PIXEL_MAX        = 255;

  localparam int SAMPLE_BITS_DEF  = 8;
  localparam int FRAC_BITS_DEF    = 8;
  localparam int SAMPLE_BITS_MAX  = 16;
  localparam int FRAC_BITS_MAX    = 16;

  localparam int POINTS           = 4;
  localparam int LANES            = 4;
  localparam int LANE_STAGES      = 4;
  localparam int LANE_GROW        = 5;
  localparam int LANE_OUT_GROW    = 4;

  localparam int COLUMN_EXT_BITS  = POINTS * SAMPLE_BITS_MAX;
  localparam int FRAC_EXT_BITS    = FRAC_FIELD_BITS + FRAC_BITS_MAX;

endpackage

### src/bik_in_if.sv
// ----------------------------------------------------------------------------
// Bicubic kernel input channel
// Valid/ready channel that carries one 4x4 window and two fractions per item.
// ----------------------------------------------------------------------------
interface bik_in_if;
  import bik_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [COLUMN_BITS-1:0]     column0_samples;
  logic [COLUMN_BITS-1:0]     column1_samples;
  logic [COLUMN_BITS-1:0]     column2_samples;
  logic [COLUMN_BITS-1:0]     column3_samples;
  logic [FRAC_FIELD_BITS-1:0] frac_x;
  logic [FRAC_FIELD_BITS-1:0] frac_y;

  modport source (
    output valid, column0_samples, column1_samples, column2_samples,
           column3_samples, frac_x, frac_y,
    input  ready
  );

  modport sink (
    input  valid, column0_samples, column1_samples, column2_samples,
           column3_samples, frac_x, frac_y,
    output ready
  );

endinterface

### src/bik_out_if.sv
// ----------------------------------------------------------------------------
// Bicubic kernel result channel
// Valid/ready channel that carries one interpolated pixel per item.
// ----------------------------------------------------------------------------
interface bik_out_if;
  import bik_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;

  modport source (
    output valid, pixel_out,
    input  ready
  );

  modport sink (
    input  valid, pixel_out,
    output ready
  );

endinterface

### src/bik_cubic_lane.sv
// ----------------------------------------------------------------------------
// Bicubic kernel cubic lane
// Four-stage Catmull-Rom evaluator in Horner form: the first stage forms the
// coefficients and each of the next three holds one multiply. Every
// fixed-point step rounds toward minus infinity.
// ----------------------------------------------------------------------------
module bik_cubic_lane #(
  parameter int PW        = 17,
  parameter int FRAC_BITS = bik_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [FRAC_BITS-1:0]                    t,
  input  logic signed [PW-1:0]                    p [bik_pkg::POINTS],
  output logic signed [PW+bik_pkg::LANE_OUT_GROW-1:0] f
);
  import bik_pkg::*;

  localparam int IW = PW + LANE_GROW;
  localparam int OW = PW + LANE_OUT_GROW;
  localparam int MW = IW + FRAC_BITS + 1;

  logic signed [IW-1:0] xp [POINTS];
  logic signed [IW-1:0] diff12;
  logic signed [IW-1:0] a_nxt, b_nxt, c_nxt;
  logic signed [MW-1:0] mul_u, mul_v, mul_w;
  logic signed [IW-1:0] sum_v, sum_w;

  logic signed [IW-1:0]   a1_r, b1_r, c1_r;
  logic signed [PW-1:0]   p1_1_r, p1_2_r, p1_3_r, p1_4_r;
  logic [FRAC_BITS-1:0]   t1_r, t2_r, t3_r;
  logic signed [IW-1:0]   a2_r, b2_r, u2_r;
  logic signed [IW-1:0]   a3_r, v3_r;
  logic signed [IW-1:0]   w4_r;

  always_comb begin
    for (int i = 0; i < POINTS; i++) begin
      xp[i] = {{LANE_GROW{p[i][PW-1]}}, p[i]};
    end
    diff12 = xp[1] - xp[2];
    a_nxt  = xp[2] - xp[0];
    b_nxt  = (xp[0] <<< 1) - (xp[1] <<< 2) - xp[1] + (xp[2] <<< 2) - xp[3];
    c_nxt  = (diff12 <<< 1) + diff12 + xp[3] - xp[0];
  end

  assign mul_u = c1_r * $signed({1'b0, t1_r});
  assign sum_v = b2_r + u2_r;
  assign mul_v = sum_v * $signed({1'b0, t2_r});
  assign sum_w = a3_r + v3_r;
  assign mul_w = sum_w * $signed({1'b0, t3_r});

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= a_nxt;
      b1_r   <= b_nxt;
      c1_r   <= c_nxt;
      p1_1_r <= p[1];
      t1_r   <= t;

      a2_r   <= a1_r;
      b2_r   <= b1_r;
      u2_r   <= mul_u[FRAC_BITS +: IW];
      p1_2_r <= p1_1_r;
      t2_r   <= t1_r;

      a3_r   <= a2_r;
      v3_r   <= mul_v[FRAC_BITS +: IW];
      p1_3_r <= p1_2_r;
      t3_r   <= t2_r;

      w4_r   <= mul_w[FRAC_BITS +: IW];
      p1_4_r <= p1_3_r;
    end
  end

  assign f = {{LANE_OUT_GROW{p1_4_r[PW-1]}}, p1_4_r} + w4_r[1 +: OW];

endmodule

### src/bik_merge.sv
// ----------------------------------------------------------------------------
// Bicubic kernel merge stage
// Interpolates the four column results along x and clamps the final value
// to the pixel range.
// ----------------------------------------------------------------------------
module bik_merge #(
  parameter int SAMPLE_BITS = bik_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = bik_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [FRAC_BITS-1:0]                          tx,
  input  logic signed [SAMPLE_BITS+FRAC_BITS+bik_pkg::LANE_OUT_GROW:0]
                                                        col [bik_pkg::LANES],
  output logic [bik_pkg::PIXEL_BITS-1:0]                pixel
);
  import bik_pkg::*;

  localparam int PWX = SAMPLE_BITS + FRAC_BITS + LANE_OUT_GROW + 1;
  localparam int OWX = PWX + LANE_OUT_GROW;
  localparam int HW  = OWX - FRAC_BITS;

  logic signed [OWX-1:0] val;
  logic [HW-1:0]         whole;

  bik_cubic_lane #(
    .PW        (PWX),
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_x (
    .clk (clk),
    .en  (en),
    .t   (tx),
    .p   (col),
    .f   (val)
  );

  assign whole = val[OWX-1:FRAC_BITS];

  always_comb begin
    if (val[OWX-1]) begin
      pixel = '0;
    end else if (whole > HW'(PIXEL_MAX)) begin
      pixel = PIXEL_BITS'(PIXEL_MAX);
    end else begin
      pixel = whole[PIXEL_BITS-1:0];
    end
  end

endmodule

### src/bicubic_interpolation_kernel_core.sv
// ----------------------------------------------------------------------------
// Bicubic interpolation kernel core
// Catmull-Rom bicubic interpolation of a 4x4 window in fixed point: four
// column lanes interpolate along y, a merge lane interpolates along x.
//
// Channel  Role    Payload
// in_if    sink    column0..3_samples, frac_x, frac_y
// out_if   source  pixel_out
//
// One item is accepted every clock unless the pipeline halts. A result passes
// four stages of column lanes, four of the merge lane and one output register.
// Each lane forms its coefficients in one stage and gives one stage to each
// of its three multiplies, which sets the stage count.
// The whole pipeline advances as one; it halts only while a result waits
// in the output register and the sink is not ready.
// Reset clears the valid pipeline and the output valid bit; no other setup.
// ----------------------------------------------------------------------------
module bicubic_interpolation_kernel_core #(
  parameter int SAMPLE_BITS = bik_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = bik_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bik_in_if.sink       in_if,
  bik_out_if.source    out_if
);
  import bik_pkg::*;

  localparam int LAT = 2 * LANE_STAGES;
  localparam int PWY = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int OWY = PWY + LANE_OUT_GROW;

  logic                       en;
  logic [LAT-1:0]             vld_r, vld_nxt;
  logic                       out_valid_r;
  logic [PIXEL_BITS-1:0]      pixel_r;
  logic [PIXEL_BITS-1:0]      pixel;
  logic [COLUMN_BITS-1:0]     column [LANES];
  logic [FRAC_EXT_BITS-1:0]   fx_ext, fy_ext;
  logic [FRAC_BITS-1:0]       tx, ty;
  logic [FRAC_BITS-1:0]       tx_pipe_r [LANE_STAGES];
  logic signed [OWY-1:0]      col_f [LANES];

  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  assign column[0] = in_if.column0_samples;
  assign column[1] = in_if.column1_samples;
  assign column[2] = in_if.column2_samples;
  assign column[3] = in_if.column3_samples;

  assign fx_ext = {{(FRAC_EXT_BITS-FRAC_FIELD_BITS){1'b0}}, in_if.frac_x};
  assign fy_ext = {{(FRAC_EXT_BITS-FRAC_FIELD_BITS){1'b0}}, in_if.frac_y};
  assign tx     = fx_ext[FRAC_BITS-1:0];
  assign ty     = fy_ext[FRAC_BITS-1:0];

  for (genvar c = 0; c < LANES; c++) begin : g_col
    logic [COLUMN_EXT_BITS-1:0] col_ext;
    logic signed [PWY-1:0]      pts [POINTS];

    assign col_ext = {{(COLUMN_EXT_BITS-COLUMN_BITS){1'b0}}, column[c]};

    for (genvar s = 0; s < POINTS; s++) begin : g_pt
      assign pts[s] = {1'b0, col_ext[s*SAMPLE_BITS +: SAMPLE_BITS], {FRAC_BITS{1'b0}}};
    end

    bik_cubic_lane #(
      .PW        (PWY),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane_y (
      .clk (clk),
      .en  (en),
      .t   (ty),
      .p   (pts),
      .f   (col_f[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_pipe_r[0] <= tx;
      for (int i = 1; i < LANE_STAGES; i++) begin
        tx_pipe_r[i] <= tx_pipe_r[i-1];
      end
    end
  end

  bik_merge #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_merge (
    .clk   (clk),
    .en    (en),
    .tx    (tx_pipe_r[LANE_STAGES-1]),
    .col   (col_f),
    .pixel (pixel)
  );

  assign vld_nxt = {vld_r[LAT-2:0], in_if.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_r <= pixel;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.pixel_out = pixel_r;

  // A result leaving the last lane stage must land in the output register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[LAT-1] |=> out_valid_r)
    else $error("result lost between the merge lane and the output register");

  // A stalled pipeline must not move its valid bits and must keep its output valid.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && out_valid_r)
    else $error("pipeline moved while stalled");

  // Reset empties the pipeline and the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0 && !out_valid_r)
    else $error("pipeline not empty after reset");

endmodule
